// ----- design/evms_pkg.sv -----
// shared types and constants for the element von mises stress block
package evms_pkg;

    localparam int MAX_ELEMENTS = 65536;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS);
    localparam int DISP_W       = 16;
    localparam int DIFF_W       = DISP_W + 1;
    localparam int SHEAR_W      = DISP_W + 3;
    localparam int STRESS_W     = 51;
    localparam int NUM_W        = 16;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int CSQ_W        = 2 * SHEAR_W;
    localparam int SUM_W        = 40;
    localparam int PSUM_W       = 37;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // s0 = 120*(2x+y), s1 = 120*(x+2y), t = 60*c
    // q = 10800 * (4*(x*x + x*y + y*y) + c*c)
    localparam logic [STRESS_W-1:0] STRESS_SCALE = STRESS_W'(10800);

    typedef logic signed [DISP_W-1:0]  t_disp;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [SHEAR_W-1:0] t_shear;

    typedef struct packed {
        logic  plane_present;
        t_disp disp_origin_row;
        t_disp disp_origin_col;
        t_disp disp_below_row;
        t_disp disp_below_col;
        t_disp disp_right_row;
        t_disp disp_right_col;
        t_disp disp_diag_row;
        t_disp disp_diag_col;
        logic  last_cell;
    } t_cell_in;

    typedef struct packed {
        logic                element_valid;
        logic [NUM_W-1:0]    element_number;
        logic [STRESS_W-1:0] stress_lower;
        logic [STRESS_W-1:0] stress_upper;
        logic [STRESS_W-1:0] max_stress;
        logic                grid_done;
    } t_elem_out;

    typedef struct packed {
        t_diff  x;
        t_diff  y;
        t_shear c;
    } t_tri;

    typedef struct packed {
        logic present;
        logic last;
        t_tri lower;
        t_tri upper;
    } t_entry;

endpackage

// ----- design/evms_front.sv -----
// front end: classifies a cell and reduces each triangle to its difference terms
module evms_front import evms_pkg::*; (
    input  t_cell_in i_cell,
    output t_entry   o_entry
);

    t_tri lower;
    t_tri upper;

    always_comb begin
        lower.x = DIFF_W'(i_cell.disp_below_row) - DIFF_W'(i_cell.disp_origin_row);
        lower.y = DIFF_W'(i_cell.disp_right_col) - DIFF_W'(i_cell.disp_origin_col);
        lower.c = SHEAR_W'(i_cell.disp_below_col) + SHEAR_W'(i_cell.disp_right_row)
                - SHEAR_W'(i_cell.disp_origin_row) - SHEAR_W'(i_cell.disp_origin_col);

        upper.x = DIFF_W'(i_cell.disp_right_row) - DIFF_W'(i_cell.disp_diag_row);
        upper.y = DIFF_W'(i_cell.disp_below_col) - DIFF_W'(i_cell.disp_diag_col);
        upper.c = SHEAR_W'(i_cell.disp_right_col) + SHEAR_W'(i_cell.disp_below_row)
                - SHEAR_W'(i_cell.disp_diag_row) - SHEAR_W'(i_cell.disp_diag_col);

        o_entry.present = i_cell.plane_present;
        o_entry.last    = i_cell.last_cell;
        // empty cell: zero terms give zero stress
        o_entry.lower   = i_cell.plane_present ? lower : '0;
        o_entry.upper   = i_cell.plane_present ? upper : '0;
    end

endmodule

// ----- design/evms_queue.sv -----
// short fifo of classified cells between front and back
module evms_queue import evms_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_not_empty,
    output t_entry o_pop_data
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full      = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/evms_back.sv -----
// back end: squares, sums, scaling, running maximum and element count
module evms_back import evms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_entry_valid,
    input  t_entry    i_entry,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_elem_out o_out
);

    logic advance;

    // stage 1 products
    logic                    r_s1_valid;
    logic                    r_s1_present;
    logic                    r_s1_last;
    logic signed [SQ_W-1:0]  r_s1_xx [2];
    logic signed [SQ_W-1:0]  r_s1_xy [2];
    logic signed [SQ_W-1:0]  r_s1_yy [2];
    logic signed [CSQ_W-1:0] r_s1_cc [2];

    // stage 2 sums
    logic                    r_s2_valid;
    logic                    r_s2_present;
    logic                    r_s2_last;
    logic [PSUM_W-1:0]       r_s2_sum [2];
    logic signed [SUM_W-1:0] n_sum [2];

    // stage 3 scaled stress
    logic                    r_s3_valid;
    logic                    r_s3_present;
    logic                    r_s3_last;
    logic [STRESS_W-1:0]     r_s3_q [2];

    // accumulation and output
    logic [CNT_W-1:0]        r_count;
    logic [STRESS_W-1:0]     r_max;
    logic                    r_out_valid;
    t_elem_out               r_out;
    logic [STRESS_W-1:0]     max_a;
    logic [STRESS_W-1:0]     max_b;
    logic [CNT_W-1:0]        n_count;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_take      = advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_sum[i] = ((SUM_W'(r_s1_xx[i]) + SUM_W'(r_s1_xy[i]) + SUM_W'(r_s1_yy[i])) <<< 2)
                     + SUM_W'(r_s1_cc[i]);
        end
        max_a = (r_s3_q[0] > r_max) ? r_s3_q[0] : r_max;
        max_b = (r_s3_q[1] > max_a) ? r_s3_q[1] : max_a;
        if (r_count == CNT_W'(MAX_ELEMENTS - 1)) begin
            n_count = '0;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_present <= i_entry.present;
            r_s1_last    <= i_entry.last;
            r_s1_xx[0]   <= SQ_W'(i_entry.lower.x) * SQ_W'(i_entry.lower.x);
            r_s1_xy[0]   <= SQ_W'(i_entry.lower.x) * SQ_W'(i_entry.lower.y);
            r_s1_yy[0]   <= SQ_W'(i_entry.lower.y) * SQ_W'(i_entry.lower.y);
            r_s1_cc[0]   <= CSQ_W'(i_entry.lower.c) * CSQ_W'(i_entry.lower.c);
            r_s1_xx[1]   <= SQ_W'(i_entry.upper.x) * SQ_W'(i_entry.upper.x);
            r_s1_xy[1]   <= SQ_W'(i_entry.upper.x) * SQ_W'(i_entry.upper.y);
            r_s1_yy[1]   <= SQ_W'(i_entry.upper.y) * SQ_W'(i_entry.upper.y);
            r_s1_cc[1]   <= CSQ_W'(i_entry.upper.c) * CSQ_W'(i_entry.upper.c);

            r_s2_present <= r_s1_present;
            r_s2_last    <= r_s1_last;
            r_s2_sum[0]  <= n_sum[0][PSUM_W-1:0];
            r_s2_sum[1]  <= n_sum[1][PSUM_W-1:0];

            r_s3_present <= r_s2_present;
            r_s3_last    <= r_s2_last;
            r_s3_q[0]    <= STRESS_W'(r_s2_sum[0]) * STRESS_SCALE;
            r_s3_q[1]    <= STRESS_W'(r_s2_sum[1]) * STRESS_SCALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_max       <= '0;
        end else if (advance) begin
            r_s1_valid  <= i_entry_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_out.element_valid  <= r_s3_present;
                r_out.element_number <= r_s3_present ? NUM_W'(r_count) : '0;
                r_out.stress_lower   <= r_s3_q[0];
                r_out.stress_upper   <= r_s3_q[1];
                r_out.max_stress     <= max_b;
                r_out.grid_done      <= r_s3_last;
                if (r_s3_last) begin
                    r_count <= '0;
                    r_max   <= '0;
                end else begin
                    r_max <= max_b;
                    if (r_s3_present) begin
                        r_count <= n_count;
                    end
                end
            end
        end
    end

endmodule

// ----- design/element_von_mises_stress.sv -----
// top level of the element von mises stress block
//
//   channel  direction  payload     handshake
//   in       input      i_in        i_in_valid / o_in_stall
//   out      output     o_out       o_out_valid / i_out_stall
//
// one cell per cycle sustained while i_out_stall stays low; before the output goes valid a cell
// passes the queue write at the transfer edge, then product, sum, scale and result register stages
// the back pipeline moves whenever the result register is empty or taken
// the input stalls only when the four-entry queue is full
// reset clears the queue, pipeline valids, element counter and running maximum
module element_von_mises_stress import evms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_cell_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_elem_out o_out
);

    t_entry front_entry;
    t_entry queue_entry;
    logic   queue_full;
    logic   queue_not_empty;
    logic   back_take;

    assign o_in_stall = queue_full;

    evms_front u_front (
        .i_cell  (i_in),
        .o_entry (front_entry)
    );

    evms_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (front_entry),
        .o_full      (queue_full),
        .i_pop       (back_take),
        .o_not_empty (queue_not_empty),
        .o_pop_data  (queue_entry)
    );

    evms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (queue_not_empty),
        .i_entry       (queue_entry),
        .o_take        (back_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

endmodule
